### rtl/core/iuh_pkg.sv
// ----------------------------------------------------------------------------
// iuh_pkg
// Shared types and constants for the interflow unit-hydrograph routing block.
// ----------------------------------------------------------------------------
package iuh_pkg;

  // Field widths of the item and result channels.
  localparam int OP_W     = 2;
  localparam int CELL_W   = 12;
  localparam int LAGF_W   = 4;
  localparam int WEIGHT_W = 16;
  localparam int SUBF_W   = 4;
  localparam int RUNOFF_W = 20;
  localparam int AREA_W   = 24;
  localparam int KIND_W   = 1;
  localparam int BIDX_W   = 4;
  localparam int FLOW_W   = 48;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_CELL = 2'd1;
  localparam logic [OP_W-1:0] OP_END  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_FLOW = 1'b0;
  localparam logic [KIND_W-1:0] KIND_ERR  = 1'b1;

  // Configuration registers.
  localparam int TS_W  = 17;
  localparam int NSB_W = 4;
  localparam logic        REG_TIME_STEP = 1'b0;
  localparam logic        REG_SUBBASINS = 1'b1;
  localparam logic [TS_W-1:0]  TS_RESET  = 17'd3600;
  localparam logic [NSB_W-1:0] NSB_RESET = 4'd1;

  // Arithmetic widths: runoff times area, times weight, over 1e6 times step.
  localparam int RA_W   = RUNOFF_W + AREA_W;   // 44
  localparam int PROD_W = RA_W + WEIGHT_W;     // 60
  localparam int DEN_W  = 37;
  localparam int QUO_W  = 41;                  // divisor is at least 1e6
  localparam logic [19:0] UM_PER_M = 20'd1000000;
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  // Divider handshake.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturating addition of a flow value.
  function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                 input logic [FLOW_W-1:0] b);
    logic [FLOW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FLOW_W] ? FLOW_MAX : s[FLOW_W-1:0];
  endfunction

endpackage

### rtl/core/iuh_ifs.sv
// ----------------------------------------------------------------------------
// iuh_ifs
// Channel interfaces for routing items and routing results.
// ----------------------------------------------------------------------------
interface iuh_item_if;
  logic                          valid;
  logic                          ready;
  logic [iuh_pkg::OP_W-1:0]      op;
  logic [iuh_pkg::CELL_W-1:0]    cell_req;
  logic [iuh_pkg::LAGF_W-1:0]    lag;
  logic [iuh_pkg::WEIGHT_W-1:0]  weight;
  logic [iuh_pkg::SUBF_W-1:0]    subbasin;
  logic [iuh_pkg::RUNOFF_W-1:0]  runoff_um;
  logic [iuh_pkg::AREA_W-1:0]    cell_area_m2;

  modport source (output valid, op, cell_req, lag, weight, subbasin, runoff_um,
                  cell_area_m2, input ready);
  modport sink (input valid, op, cell_req, lag, weight, subbasin, runoff_um,
                cell_area_m2, output ready);
endinterface

interface iuh_result_if;
  logic                        valid;
  logic                        ready;
  logic [iuh_pkg::KIND_W-1:0]  kind;
  logic [iuh_pkg::BIDX_W-1:0]  basin_index;
  logic [iuh_pkg::FLOW_W-1:0]  flow_total;
  logic                        last;

  modport source (output valid, kind, basin_index, flow_total, last, input ready);
  modport sink (input valid, kind, basin_index, flow_total, last, output ready);
endinterface

### rtl/core/iuh_interflow_routing.sv
// ----------------------------------------------------------------------------
// iuh_interflow_routing
// Per-cell unit-hydrograph routing of interflow with subbasin accumulation.
// ----------------------------------------------------------------------------
// Channel   Dir  Role                          Transaction
// items     in   weight load, cell, end step   valid & ready at rising edge
// results   out  flow totals and errors        valid & ready at rising edge
// apb       in   time step, subbasins in use   psel & penable & pwrite
//
// A cell item works through each lag in turn: each lag is a memory read, two
// partial products and a bit-serial division; a lag with zero weight, zero
// runoff or zero cell area skips the divider.
// An end-of-step item sums nsub subbasin totals, then gives the total and
// one result per subbasin. After reset a clearing pass over all CELLS*LAGS
// addresses zeroes both memories while no item is accepted. A stalled
// result holds the block until it is taken.
// ----------------------------------------------------------------------------
module iuh_interflow_routing #(
  parameter int CELLS     = 4096,
  parameter int LAGS      = 16,
  parameter int SUBBASINS = 15
) (
  input  logic        clk,
  input  logic        rst,
  iuh_item_if.sink    items,
  iuh_result_if.source results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH  = CELLS * LAGS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LAG_W  = $clog2(LAGS);
  localparam int J_W    = LAG_W + 1;
  localparam int SB_W   = $clog2(SUBBASINS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;
  localparam logic [3:0] S_TOT  = 4'd9;
  localparam logic [3:0] S_EMT  = 4'd10;
  localparam logic [3:0] S_EMN  = 4'd11;

  // Configuration registers.
  logic [iuh_pkg::TS_W-1:0]  time_step;
  logic [iuh_pkg::NSB_W-1:0] nsb_cfg;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= iuh_pkg::TS_RESET;
      nsb_cfg   <= iuh_pkg::NSB_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        iuh_pkg::REG_TIME_STEP: time_step <= pwdata[iuh_pkg::TS_W-1:0];
        iuh_pkg::REG_SUBBASINS: nsb_cfg   <= pwdata[iuh_pkg::NSB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      iuh_pkg::REG_TIME_STEP: prdata = 32'(time_step);
      iuh_pkg::REG_SUBBASINS: prdata = 32'(nsb_cfg);
      default:                prdata = '0;
    endcase
  end

  // Effective subbasin count and divisor.
  logic [SB_W-1:0]           nsub;
  logic [iuh_pkg::DEN_W-1:0] den;

  always_comb begin
    if (nsb_cfg == '0) begin
      nsub = SB_W'(1);
    end else if (7'(nsb_cfg) > 7'(SUBBASINS)) begin
      nsub = SB_W'(SUBBASINS);
    end else begin
      nsub = SB_W'(nsb_cfg);
    end
  end

  always_ff @(posedge clk) begin
    den <= iuh_pkg::DEN_W'(iuh_pkg::UM_PER_M) *
           iuh_pkg::DEN_W'((time_step == '0) ? iuh_pkg::TS_W'(1) : time_step);
  end

  // Control and working registers.
  logic [3:0]                 state;
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          base;
  logic [J_W-1:0]             j;
  logic [iuh_pkg::RA_W-1:0]   ra;
  logic [SB_W-1:0]            target;
  logic [SB_W-1:0]            n;
  logic [iuh_pkg::FLOW_W-1:0] old_flow;
  logic [iuh_pkg::FLOW_W-1:0] add_flow;
  logic [iuh_pkg::FLOW_W-1:0] lag0;
  logic [iuh_pkg::FLOW_W-1:0] total;
  logic [47:0]                p_lo;
  logic [27:0]                p_hi;
  logic                       skip;
  logic [iuh_pkg::SUBF_W-1:0] err_sub;
  logic [iuh_pkg::FLOW_W-1:0] sums [SUBBASINS + 1];

  // Memories.
  logic                         w_we;
  logic [ADDR_W-1:0]            w_waddr;
  logic [iuh_pkg::WEIGHT_W-1:0] w_wdata;
  logic [ADDR_W-1:0]            w_raddr;
  logic [iuh_pkg::WEIGHT_W-1:0] w_rdata;
  logic                         f_we;
  logic [ADDR_W-1:0]            f_waddr;
  logic [iuh_pkg::FLOW_W-1:0]   f_wdata;
  logic [ADDR_W-1:0]            f_raddr;
  logic [iuh_pkg::FLOW_W-1:0]   f_rdata;

  iuh_ram #(.WIDTH(iuh_pkg::WEIGHT_W), .DEPTH(DEPTH)) u_weights (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  iuh_ram #(.WIDTH(iuh_pkg::FLOW_W), .DEPTH(DEPTH)) u_flows (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // Divider.
  iuh_pkg::div_ctl_t          div_ctl;
  iuh_pkg::div_stat_t         div_stat;
  logic [iuh_pkg::PROD_W-1:0] prod;
  logic [iuh_pkg::QUO_W-1:0]  quotient;

  assign prod = iuh_pkg::PROD_W'(p_lo) + (iuh_pkg::PROD_W'(p_hi) << 32);
  assign div_ctl.start = (state == S_SUM) && !skip;

  iuh_div u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl), .dividend(prod), .divisor(den),
    .stat(div_stat), .quotient(quotient)
  );

  // Item decode.
  logic                 accept;
  logic                 cell_ok;
  logic                 lag_ok;
  logic                 sub_bad;
  logic [31:0]          cell_base;
  logic [iuh_pkg::FLOW_W-1:0] new_flow;

  assign items.ready = (state == S_IDLE);
  assign accept   = items.valid && items.ready;
  assign cell_ok  = (17'(items.cell_req) < 17'(CELLS));
  assign lag_ok   = (7'(items.lag) < 7'(LAGS));
  assign sub_bad  = (nsub != SB_W'(1)) && (7'(items.subbasin) > 7'(nsub));
  assign cell_base = 32'(items.cell_req) * 32'(LAGS);
  assign new_flow = iuh_pkg::sat_add(old_flow, add_flow);

  // Memory port selection.
  always_comb begin
    w_we    = 1'b0;
    w_waddr = clr_addr;
    w_wdata = '0;
    f_we    = 1'b0;
    f_waddr = clr_addr;
    f_wdata = '0;
    if (state == S_CLR) begin
      w_we = 1'b1;
      f_we = 1'b1;
    end else if (accept && items.op == iuh_pkg::OP_LOAD && cell_ok && lag_ok) begin
      w_we    = 1'b1;
      w_waddr = ADDR_W'(cell_base + 32'(items.lag));
      w_wdata = items.weight;
    end
    if (state == S_WR) begin
      f_we    = 1'b1;
      f_waddr = base + ADDR_W'(j);
      f_wdata = new_flow;
    end
    w_raddr = base + ADDR_W'(j);
    f_raddr = base + ADDR_W'(j) + ADDR_W'(1);
  end

  // Output register.
  logic                          out_valid;
  logic                          out_free;
  logic                          out_load;
  logic [iuh_pkg::KIND_W-1:0]    out_kind;
  logic [iuh_pkg::BIDX_W-1:0]    out_idx;
  logic [iuh_pkg::FLOW_W-1:0]    out_flow;
  logic                          out_last;
  logic [iuh_pkg::KIND_W-1:0]    ld_kind;
  logic [iuh_pkg::BIDX_W-1:0]    ld_idx;
  logic [iuh_pkg::FLOW_W-1:0]    ld_flow;
  logic                          ld_last;

  assign out_free = !out_valid || results.ready;

  always_comb begin
    out_load = 1'b0;
    ld_kind  = iuh_pkg::KIND_FLOW;
    ld_idx   = '0;
    ld_flow  = total;
    ld_last  = 1'b0;
    unique case (state)
      S_ERR: begin
        out_load = out_free;
        ld_kind  = iuh_pkg::KIND_ERR;
        ld_idx   = err_sub;
        ld_flow  = '0;
      end
      S_EMT: begin
        out_load = out_free;
      end
      S_EMN: begin
        out_load = out_free;
        ld_idx   = iuh_pkg::BIDX_W'(n);
        ld_flow  = sums[n];
        ld_last  = (n == nsub);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= ld_kind;
      out_idx  <= ld_idx;
      out_flow <= ld_flow;
      out_last <= ld_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.kind        = out_kind;
  assign results.basin_index = out_idx;
  assign results.flow_total  = out_flow;
  assign results.last        = out_last;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      j        <= '0;
      n        <= '0;
      for (int k = 0; k <= SUBBASINS; k++) begin
        sums[k] <= '0;
      end
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (items.op)
              iuh_pkg::OP_CELL: begin
                if (cell_ok) begin
                  err_sub <= items.subbasin;
                  if (sub_bad) begin
                    state <= S_ERR;
                  end else begin
                    state  <= S_RD;
                    j      <= '0;
                    base   <= ADDR_W'(cell_base);
                    ra     <= iuh_pkg::RA_W'(items.runoff_um) *
                              iuh_pkg::RA_W'(items.cell_area_m2);
                    target <= (nsub == SB_W'(1)) ? SB_W'(1) : SB_W'(items.subbasin);
                  end
                end
              end
              iuh_pkg::OP_END: begin
                state <= S_TOT;
                n     <= SB_W'(1);
                total <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          old_flow <= (j == J_W'(LAGS - 1)) ? '0 : f_rdata;
          p_lo     <= ra[31:0] * w_rdata;
          p_hi     <= ra[iuh_pkg::RA_W-1:32] * w_rdata;
          skip     <= (w_rdata == '0) || (ra == '0);
          state    <= S_SUM;
        end
        S_SUM: begin
          if (skip) begin
            add_flow <= '0;
            state    <= S_WR;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            add_flow <= iuh_pkg::FLOW_W'(quotient);
            state    <= S_WR;
          end
        end
        S_WR: begin
          if (j == '0) begin
            lag0 <= new_flow;
          end
          if (j == J_W'(LAGS - 1)) begin
            state <= S_ACC;
          end else begin
            j     <= j + J_W'(1);
            state <= S_RD;
          end
        end
        S_ACC: begin
          if (target != '0) begin
            sums[target] <= iuh_pkg::sat_add(sums[target], lag0);
          end
          state <= S_IDLE;
        end
        S_ERR: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_TOT: begin
          total <= iuh_pkg::sat_add(total, sums[n]);
          if (n == nsub) begin
            state <= S_EMT;
          end else begin
            n <= n + SB_W'(1);
          end
        end
        S_EMT: begin
          if (out_free) begin
            n     <= SB_W'(1);
            state <= S_EMN;
          end
        end
        S_EMN: begin
          if (out_free) begin
            if (n == nsub) begin
              for (int k = 0; k <= SUBBASINS; k++) begin
                sums[k] <= '0;
              end
              state <= S_IDLE;
            end else begin
              n <= n + SB_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == iuh_pkg::KIND_ERR |->
      results.flow_total == '0 && !results.last)
    else $error("error result carries flow or last");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    f_we |-> state == S_CLR || state == S_WR)
    else $error("flow memory written outside clear or write-back");

endmodule

### rtl/core/iuh_ram.sv
// ----------------------------------------------------------------------------
// iuh_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module iuh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/iuh_div.sv
// ----------------------------------------------------------------------------
// iuh_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// QUO_W bits because the divisor is never below one million.
// ----------------------------------------------------------------------------
module iuh_div (
  input  logic                         clk,
  input  logic                         rst,
  input  iuh_pkg::div_ctl_t            ctl,
  input  logic [iuh_pkg::PROD_W-1:0]   dividend,
  input  logic [iuh_pkg::DEN_W-1:0]    divisor,
  output iuh_pkg::div_stat_t           stat,
  output logic [iuh_pkg::QUO_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(iuh_pkg::QUO_W + 1);
  localparam int HI_W  = iuh_pkg::PROD_W - iuh_pkg::QUO_W;

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [iuh_pkg::DEN_W-1:0]   rem;
  logic [iuh_pkg::DEN_W-1:0]   den;
  logic [iuh_pkg::QUO_W-1:0]   dvd;
  logic [iuh_pkg::DEN_W:0]     trial;
  logic [iuh_pkg::DEN_W:0]     diff;
  logic                        qbit;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem, dvd[iuh_pkg::QUO_W-1]};
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(iuh_pkg::QUO_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the upper dividend bits start as the remainder.
  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      rem <= iuh_pkg::DEN_W'(dividend[iuh_pkg::PROD_W-1 -: HI_W]);
      dvd <= dividend[iuh_pkg::QUO_W-1:0];
      den <= divisor;
    end else if (busy) begin
      rem <= qbit ? diff[iuh_pkg::DEN_W-1:0] : trial[iuh_pkg::DEN_W-1:0];
      dvd <= {dvd[iuh_pkg::QUO_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule
